// ===== design/kst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Request codes, status codes and fixed field widths for the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int REQ_W  = 3;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
  localparam logic [REQ_W-1:0] REQ_CREATE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PACK   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

endpackage

// ===== design/kst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface kst_req_if
  import kst_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] payload;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, req_type, key, payload, slot, input ready);
  modport sink   (input valid, req_type, key, payload, slot, output ready);
endinterface

interface kst_rsp_if
  import kst_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic              hit;
  logic [STAT_W-1:0] status;
  logic [DATA_W-1:0] entry_data;
  logic [CNT_W-1:0]  occupied;
  logic [CNT_W-1:0]  extent;

  modport source (output valid, slot_index, hit, status, entry_data, occupied, extent,
                  input ready);
  modport sink   (input valid, slot_index, hit, status, entry_data, occupied, extent,
                  output ready);
endinterface

// ===== design/kst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/keyed_slot_table_compact_top.sv =====
`timescale 1ns / 1ps
// Flow: key requests scan the extent up to the first matching slot before the result;
//   compaction is bound by the single read port (registered read while packing).
// A new request is taken only after the previous result is in the output register.
// Reset: synchronous, active low; a clearing pass then empties every slot, during
//   which no request is taken.
// ----------------------------------------------------------------------------
// keyed_slot_table_compact_top
// Keyed slot table with first-free allocation and two-pointer compaction,
// walked one slot per step by a small sequencer over key and data RAMs.
// ----------------------------------------------------------------------------
module keyed_slot_table_compact_top
  import kst_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  logic   clk,
  input  logic   rst_n,
  kst_req_if.sink   in_ch,
  kst_rsp_if.source out_ch
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;
  localparam int KW = KEY_BITS + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_ACT  = 4'd3;
  localparam logic [3:0] S_SLRD = 4'd4;
  localparam logic [3:0] S_SLCK = 4'd5;
  localparam logic [3:0] S_HIRD = 4'd6;
  localparam logic [3:0] S_HICK = 4'd7;
  localparam logic [3:0] S_LORD = 4'd8;
  localparam logic [3:0] S_LOCK = 4'd9;
  localparam logic [3:0] S_MVHI = 4'd10;
  localparam logic [3:0] S_TRRD = 4'd11;
  localparam logic [3:0] S_TRCK = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [CW-1:0]     ext_r, ext_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic              out_valid_r, out_valid_nxt;

  // working registers
  logic [REQ_W-1:0]  req_type_r, req_type_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [DATA_BITS-1:0] pl_r, pl_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CW-1:0]     p_r, p_nxt;
  logic              pend_r, pend_nxt;
  logic [CW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  logic [CW-1:0]     where_r, where_nxt;
  logic              hole_ok_r, hole_ok_nxt;
  logic [CW-1:0]     hole_r, hole_nxt;
  logic [DATA_BITS-1:0] fdata_r, fdata_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [KEY_BITS-1:0]  mv_key_r, mv_key_nxt;
  logic [DATA_BITS-1:0] mv_data_r, mv_data_nxt;

  // result and output registers
  logic [SLOT_W-1:0] res_idx_r, res_idx_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic [STAT_W-1:0] res_stat_r, res_stat_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;
  logic [SLOT_W-1:0] o_idx_r, o_idx_nxt;
  logic              o_hit_r, o_hit_nxt;
  logic [STAT_W-1:0] o_stat_r, o_stat_nxt;
  logic [DATA_W-1:0] o_data_r, o_data_nxt;
  logic [CNT_W-1:0]  o_occ_r, o_occ_nxt;
  logic [CNT_W-1:0]  o_ext_r, o_ext_nxt;

  // RAM ports
  logic              kv_we, dt_we;
  logic [IW-1:0]     kv_wa, dt_wa, rd_addr;
  logic [KW-1:0]     kv_wd, kv_rd;
  logic [DATA_BITS-1:0] dt_wd, dt_rd;

  logic              rd_valid;
  logic              key_eq;
  logic [CW-1:0]     free_slot;

  kst_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (kv_we),
    .wr_addr (kv_wa),
    .wr_data (kv_wd),
    .rd_addr (rd_addr),
    .rd_data (kv_rd)
  );

  kst_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS)) u_data_ram (
    .clk     (clk),
    .wr_en   (dt_we),
    .wr_addr (dt_wa),
    .wr_data (dt_wd),
    .rd_addr (rd_addr),
    .rd_data (dt_rd)
  );

  assign rd_valid  = kv_rd[KEY_BITS];
  assign key_eq    = (kv_rd[KEY_BITS-1:0] == key_r);
  assign free_slot = hole_ok_r ? hole_r : ext_r;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = o_idx_r;
  assign out_ch.hit        = o_hit_r;
  assign out_ch.status     = o_stat_r;
  assign out_ch.entry_data = o_data_r;
  assign out_ch.occupied   = o_occ_r;
  assign out_ch.extent     = o_ext_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ext_nxt       = ext_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r;
    req_type_nxt  = req_type_r;
    key_nxt       = key_r;
    pl_nxt        = pl_r;
    slot_nxt      = slot_r;
    p_nxt         = p_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    found_nxt     = found_r;
    where_nxt     = where_r;
    hole_ok_nxt   = hole_ok_r;
    hole_nxt      = hole_r;
    fdata_nxt     = fdata_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mv_key_nxt    = mv_key_r;
    mv_data_nxt   = mv_data_r;
    res_idx_nxt   = res_idx_r;
    res_hit_nxt   = res_hit_r;
    res_stat_nxt  = res_stat_r;
    res_data_nxt  = res_data_r;
    o_idx_nxt     = o_idx_r;
    o_hit_nxt     = o_hit_r;
    o_stat_nxt    = o_stat_r;
    o_data_nxt    = o_data_r;
    o_occ_nxt     = o_occ_r;
    o_ext_nxt     = o_ext_r;
    kv_we         = 1'b0;
    kv_wa         = '0;
    kv_wd         = '0;
    dt_we         = 1'b0;
    dt_wa         = '0;
    dt_wd         = '0;
    rd_addr       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLR: begin
        kv_we = 1'b1;
        kv_wa = clr_r;
        if (clr_r == IW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          req_type_nxt = in_ch.req_type;
          key_nxt      = KEY_BITS'(in_ch.key);
          pl_nxt       = DATA_BITS'(in_ch.payload);
          slot_nxt     = in_ch.slot;
          res_idx_nxt  = '0;
          res_hit_nxt  = 1'b0;
          res_stat_nxt = STAT_OK;
          res_data_nxt = '0;
          p_nxt        = '0;
          pend_nxt     = 1'b0;
          found_nxt    = 1'b0;
          hole_ok_nxt  = 1'b0;
          case (in_ch.req_type)
            REQ_INSERT, REQ_LOOKUP, REQ_CREATE, REQ_REMOVE: state_nxt = S_SCAN;
            REQ_CLEAR: state_nxt = S_SLRD;
            REQ_PACK: begin
              lo_nxt = '0;
              hi_nxt = ext_r - CW'(1);
              state_nxt = (ext_r == '0) ? S_DONE : S_HIRD;
            end
            default: begin
              res_stat_nxt = STAT_NOTFOUND;
              state_nxt    = S_DONE;
            end
          endcase
        end
      end

      // one read issued and one slot compared per cycle
      S_SCAN: begin
        rd_addr = IW'(p_r);
        if (pend_r && rd_valid && key_eq) begin
          found_nxt = 1'b1;
          where_nxt = pend_idx_r;
          fdata_nxt = dt_rd;
          state_nxt = S_ACT;
        end else begin
          if (pend_r && !rd_valid && !hole_ok_r) begin
            hole_ok_nxt = 1'b1;
            hole_nxt    = pend_idx_r;
          end
          if (p_r < ext_r) begin
            pend_nxt     = 1'b1;
            pend_idx_nxt = p_r;
            p_nxt        = p_r + CW'(1);
          end else begin
            pend_nxt  = 1'b0;
            state_nxt = S_ACT;
          end
        end
      end

      S_ACT: begin
        state_nxt = S_DONE;
        case (req_type_r)
          REQ_INSERT, REQ_CREATE: begin
            if (found_r) begin
              res_idx_nxt  = SLOT_W'(where_r);
              res_hit_nxt  = 1'b1;
              res_data_nxt = DATA_W'(fdata_r);
            end else if (free_slot == CW'(SLOTS)) begin
              res_stat_nxt = STAT_FULL;
            end else begin
              kv_we = 1'b1;
              kv_wa = IW'(free_slot);
              kv_wd = {1'b1, key_r};
              dt_we = 1'b1;
              dt_wa = IW'(free_slot);
              dt_wd = (req_type_r == REQ_INSERT) ? pl_r : '0;
              occ_nxt = occ_r + CW'(1);
              if (free_slot == ext_r) begin
                ext_nxt = ext_r + CW'(1);
              end
              res_idx_nxt = SLOT_W'(free_slot);
            end
          end
          REQ_LOOKUP: begin
            if (found_r) begin
              res_idx_nxt  = SLOT_W'(where_r);
              res_hit_nxt  = 1'b1;
              res_data_nxt = DATA_W'(fdata_r);
            end else begin
              res_stat_nxt = STAT_NOTFOUND;
            end
          end
          REQ_REMOVE: begin
            if (found_r) begin
              kv_we = 1'b1;
              kv_wa = IW'(where_r);
              kv_wd = {1'b0, key_r};
              occ_nxt = occ_r - CW'(1);
              res_idx_nxt = SLOT_W'(where_r);
              res_hit_nxt = 1'b1;
            end else begin
              res_stat_nxt = STAT_NOTFOUND;
            end
          end
          default: ;
        endcase
      end

      S_SLRD: begin
        rd_addr     = IW'(slot_r);
        res_idx_nxt = slot_r;
        if (SW'(slot_r) < SW'(ext_r)) begin
          state_nxt = S_SLCK;
        end else begin
          res_stat_nxt = STAT_RANGE;
          state_nxt    = S_DONE;
        end
      end

      S_SLCK: begin
        res_hit_nxt = rd_valid;
        kv_we = 1'b1;
        kv_wa = IW'(slot_r);
        if (rd_valid) begin
          occ_nxt = occ_r - CW'(1);
        end
        state_nxt = S_DONE;
      end

      // compaction: skip empties from the top, then occupied slots from the bottom
      S_HIRD: begin
        rd_addr = IW'(hi_r);
        state_nxt = (lo_r == hi_r) ? S_TRRD : S_HICK;
      end

      S_HICK: begin
        if (!rd_valid) begin
          hi_nxt    = hi_r - CW'(1);
          state_nxt = S_HIRD;
        end else begin
          mv_key_nxt  = kv_rd[KEY_BITS-1:0];
          mv_data_nxt = dt_rd;
          state_nxt   = S_LORD;
        end
      end

      S_LORD: begin
        rd_addr = IW'(lo_r);
        state_nxt = (lo_r == hi_r) ? S_TRRD : S_LOCK;
      end

      S_LOCK: begin
        if (rd_valid) begin
          lo_nxt    = lo_r + CW'(1);
          state_nxt = S_LORD;
        end else begin
          kv_we = 1'b1;
          kv_wa = IW'(lo_r);
          kv_wd = {1'b1, mv_key_r};
          dt_we = 1'b1;
          dt_wa = IW'(lo_r);
          dt_wd = mv_data_r;
          state_nxt = S_MVHI;
        end
      end

      S_MVHI: begin
        kv_we = 1'b1;
        kv_wa = IW'(hi_r);
        kv_wd = {1'b0, mv_key_r};
        hi_nxt    = hi_r - CW'(1);
        state_nxt = S_HIRD;
      end

      // trim trailing empties, slot 0 always stays
      S_TRRD: begin
        rd_addr = IW'(ext_r - CW'(1));
        state_nxt = (ext_r > CW'(1)) ? S_TRCK : S_DONE;
      end

      S_TRCK: begin
        if (!rd_valid) begin
          ext_nxt   = ext_r - CW'(1);
          state_nxt = S_TRRD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          o_idx_nxt     = res_idx_r;
          o_hit_nxt     = res_hit_r;
          o_stat_nxt    = res_stat_r;
          o_data_nxt    = res_data_r;
          o_occ_nxt     = CNT_W'(occ_r);
          o_ext_nxt     = CNT_W'(ext_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      ext_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ext_r       <= ext_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    key_r      <= key_nxt;
    pl_r       <= pl_nxt;
    slot_r     <= slot_nxt;
    p_r        <= p_nxt;
    pend_r     <= pend_nxt;
    pend_idx_r <= pend_idx_nxt;
    found_r    <= found_nxt;
    where_r    <= where_nxt;
    hole_ok_r  <= hole_ok_nxt;
    hole_r     <= hole_nxt;
    fdata_r    <= fdata_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mv_key_r   <= mv_key_nxt;
    mv_data_r  <= mv_data_nxt;
    res_idx_r  <= res_idx_nxt;
    res_hit_r  <= res_hit_nxt;
    res_stat_r <= res_stat_nxt;
    res_data_r <= res_data_nxt;
    o_idx_r    <= o_idx_nxt;
    o_hit_r    <= o_hit_nxt;
    o_stat_r   <= o_stat_nxt;
    o_data_r   <= o_data_nxt;
    o_occ_r    <= o_occ_nxt;
    o_ext_r    <= o_ext_nxt;
  end

`ifndef ASSERT_OFF
  a_occ_le_ext: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= ext_r)
    else $error("occupied count exceeds extent");

  a_ext_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ext_r <= CW'(SLOTS))
    else $error("extent beyond table size");

  a_act_wr_in_ext: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT && kv_we) |-> (CW'(kv_wa) < ext_nxt))
    else $error("key write outside extent");

  a_pack_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HIRD || state_r == S_HICK || state_r == S_LORD ||
     state_r == S_LOCK || state_r == S_MVHI || state_r == S_TRRD ||
     state_r == S_TRCK) |=> $stable(occ_r))
    else $error("compaction changed occupied count");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed slot table. A shadow copy of the table
// predicts every result from the requests as they transfer in. Stimulus is a
// short directed opening followed by random episodes (fill, drain, even mix,
// full-table bursts), with random idling on both channels.
// ----------------------------------------------------------------------------
module tb
  import kst_pkg::*;
  ();

  localparam int SLOTS       = 64;
  localparam int ITEM_TARGET = 1650;
  localparam int POOL_SIZE   = 96;
  localparam int LONG_HOLD   = 800;
  localparam int TAIL_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_000_000;

  // request codes with no function in the block
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] payload;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              hit;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] entry_data;
    logic [CNT_W-1:0]  occupied;
    logic [CNT_W-1:0]  extent;
  } rsp_t;

  // Shadow of the table contents; predicts one result per request.
  class slot_table_shadow;
    bit [KEY_W-1:0]  keys [SLOTS];
    bit [DATA_W-1:0] vals [SLOTS];
    bit              used [SLOTS];
    int              ext;
    rsp_t            awaited_rsp [$];
    int              mismatches;

    function new();
      ext        = 0;
      mismatches = 0;
      foreach (used[i]) used[i] = 1'b0;
    endfunction

    function int pending();
      return awaited_rsp.size();
    endfunction

    // true with the matching slot, else false with the first hole or the extent
    function bit find(input bit [KEY_W-1:0] k, output int where);
      bit have_hole;
      int hole;
      have_hole = 1'b0;
      hole      = 0;
      for (int i = 0; i < ext; i++) begin
        if (!used[i]) begin
          if (!have_hole) begin
            have_hole = 1'b1;
            hole      = i;
          end
        end else if (keys[i] == k) begin
          where = i;
          return 1'b1;
        end
      end
      where = have_hole ? hole : ext;
      return 1'b0;
    endfunction

    function void squeeze();
      int lo;
      int hi;
      if (ext == 0) return;
      lo = 0;
      hi = ext - 1;
      while (lo != hi) begin
        while (lo != hi && !used[hi]) hi--;
        while (lo != hi && used[lo]) lo++;
        if (lo == hi) break;
        keys[lo] = keys[hi];
        vals[lo] = vals[hi];
        used[lo] = 1'b1;
        used[hi] = 1'b0;
      end
      // slot 0 is never trimmed
      while (ext > 1 && !used[ext-1]) ext--;
    endfunction

    function void note_request(input req_t rq);
      rsp_t e;
      int   where;
      int   n;
      e     = '0;
      where = 0;
      case (rq.req_type)
        REQ_INSERT, REQ_CREATE: begin
          if (find(rq.key, where)) begin
            e.slot_index = SLOT_W'(where);
            e.hit        = 1'b1;
            e.entry_data = vals[where];
          end else if (where >= SLOTS) begin
            e.status = STAT_FULL;
          end else begin
            keys[where] = rq.key;
            vals[where] = (rq.req_type == REQ_INSERT) ? rq.payload : '0;
            used[where] = 1'b1;
            if (where == ext) ext++;
            e.slot_index = SLOT_W'(where);
          end
        end
        REQ_LOOKUP: begin
          if (find(rq.key, where)) begin
            e.slot_index = SLOT_W'(where);
            e.hit        = 1'b1;
            e.entry_data = vals[where];
          end else begin
            e.status = STAT_NOTFOUND;
          end
        end
        REQ_REMOVE: begin
          if (find(rq.key, where)) begin
            e.slot_index = SLOT_W'(where);
            e.hit        = 1'b1;
            used[where]  = 1'b0;
          end else begin
            e.status = STAT_NOTFOUND;
          end
        end
        REQ_CLEAR: begin
          e.slot_index = rq.slot;
          if (int'(rq.slot) < ext) begin
            e.hit         = used[rq.slot];
            used[rq.slot] = 1'b0;
          end else begin
            e.status = STAT_RANGE;
          end
        end
        REQ_PACK: squeeze();
        default: e.status = STAT_NOTFOUND;
      endcase
      n = 0;
      foreach (used[i]) if (used[i]) n++;
      e.occupied = CNT_W'(n);
      e.extent   = CNT_W'(ext);
      awaited_rsp.push_back(e);
    endfunction

    function void check_result(input rsp_t got);
      rsp_t want;
      bit   bad;
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: result with nothing awaited: slot=%0d hit=%0b st=%0d data=%h occ=%0d ext=%0d",
                   got.slot_index, got.hit, got.status, got.entry_data, got.occupied,
                   got.extent);
        return;
      end
      want = awaited_rsp.pop_front();
      bad  = (got.slot_index !== want.slot_index) || (got.hit !== want.hit) ||
             (got.status !== want.status) || (got.entry_data !== want.entry_data) ||
             (got.occupied !== want.occupied) || (got.extent !== want.extent);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tb: mismatch exp slot=%0d hit=%0b st=%0d data=%h occ=%0d ext=%0d",
                   want.slot_index, want.hit, want.status, want.entry_data, want.occupied,
                   want.extent);
          $display("tb:          got slot=%0d hit=%0b st=%0d data=%h occ=%0d ext=%0d",
                   got.slot_index, got.hit, got.status, got.entry_data, got.occupied,
                   got.extent);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  kst_req_if req_ch ();
  kst_rsp_if rsp_ch ();

  keyed_slot_table_compact_top #(
    .SLOTS    (SLOTS),
    .KEY_BITS (32),
    .DATA_BITS(32)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(rsp_ch)
  );

  slot_table_shadow shadow = new();

  bit              calm;            // no idling on either side
  bit              sink_long_hold;  // request for one long receiver stall
  int              items_sent;
  int              cycle_count;
  bit [KEY_W-1:0]  key_pool [POOL_SIZE];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // result side: ready follows a per-transfer hold count
  initial begin : result_sink
    int   hold;
    bit   held_long;
    rsp_t got;
    hold         = 0;
    held_long    = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_long_hold && !held_long) begin
        hold      = LONG_HOLD;
        held_long = 1'b1;
      end
      @(negedge clk);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
        got.slot_index = rsp_ch.slot_index;
        got.hit        = rsp_ch.hit;
        got.status     = rsp_ch.status;
        got.entry_data = rsp_ch.entry_data;
        got.occupied   = rsp_ch.occupied;
        got.extent     = rsp_ch.extent;
        shadow.check_result(got);
        hold = draw_gap();
      end
    end
  end

  // Offers one request and returns just after the edge that transfers it.
  task automatic send_req(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [DATA_W-1:0] pl, input logic [SLOT_W-1:0] s);
    int   gap;
    req_t rq;
    gap = draw_gap();
    rq  = '{req_type: op, key: k, payload: pl, slot: s};
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    req_ch.payload  <= pl;
    req_ch.slot     <= s;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    shadow.note_request(rq);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item(input mix_t mix);
    int                r;
    logic [REQ_W-1:0]  op;
    logic [REQ_W-1:0]  spare;
    logic [KEY_W-1:0]  k;
    logic [SLOT_W-1:0] s;
    r     = $urandom_range(0, 99);
    spare = $urandom_range(0, 1) ? REQ_SPARE6 : REQ_SPARE7;
    case (mix)
      MIX_FILL:
        op = r < 45 ? REQ_INSERT : r < 65 ? REQ_CREATE : r < 82 ? REQ_LOOKUP :
             r < 88 ? REQ_REMOVE : r < 93 ? REQ_CLEAR  : r < 97 ? REQ_PACK   : spare;
      MIX_DRAIN:
        op = r < 10 ? REQ_INSERT : r < 15 ? REQ_CREATE : r < 35 ? REQ_LOOKUP :
             r < 65 ? REQ_REMOVE : r < 85 ? REQ_CLEAR  : r < 97 ? REQ_PACK   : spare;
      default:
        op = r < 25 ? REQ_INSERT : r < 35 ? REQ_CREATE : r < 55 ? REQ_LOOKUP :
             r < 72 ? REQ_REMOVE : r < 84 ? REQ_CLEAR  : r < 95 ? REQ_PACK   : spare;
    endcase
    // mostly pooled keys so that hits are common
    k = ($urandom_range(0, 6) == 0) ? KEY_W'($urandom) :
        key_pool[$urandom_range(0, POOL_SIZE - 1)];
    s = (shadow.ext > 0 && $urandom_range(0, 3) != 0) ?
        SLOT_W'($urandom_range(0, shadow.ext)) : SLOT_W'($urandom);
    send_req(op, k, $urandom, s);
  endtask

  initial begin : stimulus
    int   episode;
    int   len;
    mix_t mix;
    rst_n           = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = '0;
    req_ch.key      = '0;
    req_ch.payload  = '0;
    req_ch.slot     = '0;
    calm            = 1'b0;
    sink_long_hold  = 1'b0;
    items_sent      = 0;
    episode         = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed opening
    send_req(REQ_PACK,   $urandom,     $urandom,     SLOT_W'($urandom));  // empty extent
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd0);      // nothing in range yet
    send_req(REQ_LOOKUP, 32'h0,        $urandom,     SLOT_W'($urandom));
    send_req(REQ_REMOVE, 32'hFFFFFFFF, $urandom,     SLOT_W'($urandom));
    send_req(REQ_INSERT, 32'h0,        32'hFFFFFFFF, SLOT_W'($urandom));
    send_req(REQ_INSERT, 32'hFFFFFFFF, 32'h0,        SLOT_W'($urandom));
    send_req(REQ_INSERT, 32'h0,        32'h12345678, SLOT_W'($urandom));  // key present
    send_req(REQ_CREATE, 32'h5A5A5A5A, $urandom,     SLOT_W'($urandom));
    send_req(REQ_CREATE, 32'hFFFFFFFF, $urandom,     SLOT_W'($urandom));  // present
    send_req(REQ_LOOKUP, 32'h0,        $urandom,     SLOT_W'($urandom));
    send_req(REQ_LOOKUP, 32'h5A5A5A5A, $urandom,     SLOT_W'($urandom));
    send_req(REQ_REMOVE, 32'h0,        $urandom,     SLOT_W'($urandom));  // hole at 0
    send_req(REQ_INSERT, 32'hA5A5A5A5, 32'hA5A5A5A5, SLOT_W'($urandom));  // refills it
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd1);      // occupied slot
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd1);      // now a hole
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd63);
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd3);      // equal to the extent
    send_req(REQ_SPARE6, $urandom,     $urandom,     SLOT_W'($urandom));
    send_req(REQ_SPARE7, $urandom,     $urandom,     SLOT_W'($urandom));
    send_req(REQ_PACK,   $urandom,     $urandom,     SLOT_W'($urandom));
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd0);
    send_req(REQ_CLEAR,  $urandom,     $urandom,     6'd1);
    send_req(REQ_PACK,   $urandom,     $urandom,     SLOT_W'($urandom));  // keeps slot 0
    send_req(REQ_LOOKUP, 32'hA5A5A5A5, $urandom,     SLOT_W'($urandom));

    // random episodes
    while (items_sent < ITEM_TARGET) begin
      episode++;
      len  = $urandom_range(40, 120);
      calm = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 2))
        0:       mix = MIX_FILL;
        1:       mix = MIX_DRAIN;
        default: mix = MIX_EVEN;
      endcase
      if (episode % 7 == 3) begin
        // fill to capacity with fresh keys, then overflow
        if (episode == 3) sink_long_hold = 1'b1;
        repeat (SLOTS + 6) send_req(REQ_INSERT, $urandom, $urandom, SLOT_W'($urandom));
        repeat (3) send_req(REQ_CREATE, $urandom, $urandom, SLOT_W'($urandom));
        mix = MIX_DRAIN;
      end
      repeat (len) random_item(mix);
      if (episode % 5 == 0) wait_idle();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
